// ===== rtl/efp_pkg.sv =====
package efp_pkg;

	// pool geometry
	localparam int SLOTS  = 256;
	localparam int SLOT_W = 8;
	localparam int CNT_W  = 9;
	localparam int Q_W    = 16;

	// request kinds carried on s_tuser
	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	// one slot as stored in the slot memory
	typedef struct packed {
		logic [15:0] life;
		logic [31:0] birth;
		logic [31:0] color;
		logic [15:0] size;
		logic [31:0] xpos;
		logic [31:0] ypos;
	} slot_t;

	// one result item
	typedef struct packed {
		logic [CNT_W-1:0]  live_count;
		logic [15:0]       out_scale;
		logic [31:0]       out_color;
		logic [31:0]       out_y;
		logic [31:0]       out_x;
		logic              slot_live;
		logic [SLOT_W-1:0] slot_out;
		logic              accepted;
	} res_t;

	// divider handshake toward the sequencer
	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/effect_pool_fade_engine.sv =====
// Effect slot pool with fade-out.
// Requests enter on the s_ channel; the kind (create, tick, read) is on
// s_tuser. Each request gives exactly one result item on the m_ channel.
// The block works on one request at a time. A create scans the live bits
// one slot per cycle. A read fetches one slot from the memory. A tick
// walks all slots, one per cycle while they are free; a live slot holds
// the walk: one that fades goes through a memory read, serial division
// and two multiply stages, and an expired one is freed.
// Slot contents sit in one synchronous memory; a live bit per slot sits in
// flops, and the live count in a register.
// Reset clears all live bits and the count: every slot is free at once.
// The result waits in an output register; the next request is taken while
// it waits, and the block holds its finished result until m_tready frees
// the output register.
module effect_pool_fade_engine import efp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// now_frame, slot_index, pos_x, pos_y, color_argb, life_frames, start_scale
	input  logic [167:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted, slot_out, slot_live, out_x, out_y, out_color, out_scale,
	// live_count, zero pad
	output logic [135:0] m_tdata
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SCAN = 10'b0000000010,
		ST_RDA  = 10'b0000000100,
		ST_RDW  = 10'b0000001000,
		ST_TNXT = 10'b0000010000,
		ST_TRD  = 10'b0000100000,
		ST_TDIV = 10'b0001000000,
		ST_TML1 = 10'b0010000000,
		ST_TML2 = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic [SLOTS-1:0]  live_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W:0]   idx_q;
	logic [SLOT_W-1:0] addr;
	res_t              res_q;
	res_t              out_q;
	logic              ovld_q;

	// request fields held for the whole request
	logic [31:0] now_q;
	slot_t       new_q;

	// slot memory
	slot_t       mem [SLOTS];
	slot_t       rd_q;
	logic        we;
	slot_t       wdata;

	// tick datapath
	logic [31:0]  age;
	logic         div_start;
	div_rsp_t     div_rsp;
	logic [Q_W-1:0] e_q;
	logic [31:0]  prod_s1;
	logic [7:0]   alpha_s1;
	logic [24:0]  alpha_sum;
	logic [32:0]  tenth;
	logic [15:0]  shrink;

	assign addr     = idx_q[SLOT_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovld_q;
	assign m_tdata  = {5'd0, out_q};

	assign age       = now_q - rd_q.birth;
	assign div_start = (state_q == ST_TRD) && (age < {16'd0, rd_q.life});
	assign alpha_sum = ({8'd0, 17'h10000 - {1'b0, div_rsp.quot}} * 25'd255) + 25'd32768;
	// floor(x / 10) for a 16-bit x by reciprocal multiplication
	assign tenth     = {1'b0, prod_s1[31:16]} * 17'd52429;
	assign shrink    = {2'd0, tenth[32:19]};

	efp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (age[Q_W-1:0]),
		.den    (rd_q.life),
		.rsp    (div_rsp)
	);

	// memory write data: new slot on create, faded slot on tick
	always_comb begin
		we    = 1'b0;
		wdata = rd_q;
		unique case (state_q)
			ST_SCAN: begin
				we    = (idx_q < (SLOT_W+1)'(SLOTS)) && !live_q[addr];
				wdata = new_q;
			end
			ST_TML2: begin
				we                = 1'b1;
				wdata.color[31:24] = alpha_s1;
				wdata.size        = rd_q.size - shrink;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	// tick multiply stages
	always_ff @(posedge clk) begin
		if (div_rsp.done) e_q <= div_rsp.quot;
		if (div_rsp.done) alpha_s1 <= alpha_sum[23:16];
		if (state_q == ST_TML1) prod_s1 <= {16'd0, rd_q.size} * {16'd0, e_q};
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_q         <= s_tdata[31:0];
			new_q.birth   <= s_tdata[31:0];
			new_q.xpos    <= s_tdata[71:40];
			new_q.ypos    <= s_tdata[103:72];
			new_q.color   <= s_tdata[135:104];
			new_q.life    <= s_tdata[151:136];
			new_q.size    <= s_tdata[167:152];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			live_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			ovld_q  <= 1'b0;
			res_q   <= '0;
			out_q   <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != ST_DONE)) ovld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						res_q <= '{accepted: (req_t'(s_tuser) != REQ_CREATE),
							slot_out: (req_t'(s_tuser) == REQ_READ) ? s_tdata[39:32] : '0,
							default: '0};
						idx_q <= (req_t'(s_tuser) == REQ_READ) ? {1'b0, s_tdata[39:32]} : '0;
						unique case (req_t'(s_tuser))
							REQ_CREATE: state_q <= ST_SCAN;
							REQ_TICK:   state_q <= ST_TNXT;
							REQ_READ:   state_q <= ST_RDA;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (idx_q == (SLOT_W+1)'(SLOTS)) begin
						state_q <= ST_DONE;
					end else if (!live_q[addr]) begin
						res_q.accepted <= 1'b1;
						res_q.slot_out <= addr;
						if (new_q.life != '0) begin
							live_q[addr] <= 1'b1;
							count_q      <= count_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RDA: state_q <= ST_RDW;
				ST_RDW: begin
					if (live_q[addr]) begin
						res_q.slot_live <= 1'b1;
						res_q.out_x     <= rd_q.xpos;
						res_q.out_y     <= rd_q.ypos;
						res_q.out_color <= rd_q.color;
						res_q.out_scale <= rd_q.size;
					end
					state_q <= ST_DONE;
				end
				ST_TNXT: begin
					if (idx_q == (SLOT_W+1)'(SLOTS)) begin
						state_q <= ST_DONE;
					end else if (live_q[addr]) begin
						state_q <= ST_TRD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_TRD: begin
					if (div_start) begin
						state_q <= ST_TDIV;
					end else begin
						// expired: free the slot
						live_q[addr] <= 1'b0;
						count_q      <= count_q - 1'b1;
						idx_q        <= idx_q + 1'b1;
						state_q      <= ST_TNXT;
					end
				end
				ST_TDIV: if (div_rsp.done) state_q <= ST_TML1;
				ST_TML1: state_q <= ST_TML2;
				ST_TML2: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_TNXT;
				end
				ST_DONE: begin
					if (!ovld_q || m_tready) begin
						out_q   <= {count_q, res_q[$bits(res_t)-CNT_W-1:0]};
						ovld_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/efp_div.sv =====
// Bit-serial restoring divider: quot = floor(num * 2^16 / den), num < den.
module efp_div import efp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [Q_W-1:0] num,
	input  logic [Q_W-1:0] den,
	output div_rsp_t       rsp
);

	logic [Q_W:0]     rem_q;
	logic [Q_W-1:0]   quot_q;
	logic [Q_W-1:0]   den_q;
	logic [4:0]       step_q;
	logic             busy_q;
	logic             done_q;
	logic [Q_W+1:0]   rem2;
	logic             ge;

	// one quotient bit per cycle
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'(Q_W);
			end else if (busy_q) begin
				step_q <= step_q - 5'd1;
				if (step_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (Q_W+1)'(rem2 - {2'b00, den_q}) : rem2[Q_W:0];
			quot_q <= {quot_q[Q_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
